[rtl/core/bole_pkg.sv]
`timescale 1ns / 1ps

package bole_pkg;

    localparam int DEF_LIST_CAPACITY = 64;
    localparam int DEF_VALUE_WIDTH   = 32;

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 7;
    localparam int ITEM_W     = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SELECT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REPLACE = 3'd4;

endpackage

[rtl/core/bole_ram.sv]
`timescale 1ns / 1ps

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bounded_ordered_list_engine.sv]
`timescale 1ns / 1ps

// Bounded ordered list engine.
// Slave channel (i_tvalid/o_tready/i_tdata/i_tuser) takes one operation per
// item: insert, remove, select, search or replace on a list of up to
// LIST_CAPACITY values held in one single-port-write RAM.
// Master channel (o_tvalid/i_tready/o_tdata) returns one result item per
// operation, with the count and the empty and full flags after it.
// Steps per item, from input accept to result valid: replace, rejected ops,
// insert at the end and remove of the last entry go straight to the final
// step; select reads one entry; insert at p walks the entries from the
// last down to p, remove at p the entries after p up to the last; search
// reads from the first entry until a match or the end of the list.
// The walk through the RAM reads one entry per cycle; for insert and remove
// each read is written back one place up or down on the next cycle.
// One operation is in flight at a time; the next item can be taken as soon
// as a result is registered, even while that result still waits in the
// output register. If the receiver stalls, the next result holds in its
// final step until the register frees.
// Reset clears the count (empty list) and the output valid; RAM contents
// are not cleared, entries at or above the count are never read.
module bounded_ordered_list_engine #(
    parameter int LIST_CAPACITY = bole_pkg::DEF_LIST_CAPACITY,
    parameter int VALUE_WIDTH   = bole_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    // position[6:0], item_value[38:7]
    input  logic [bole_pkg::IN_TDATA_W-1:0]   i_tdata,
    // opcode[2:0]
    input  logic [bole_pkg::OPCODE_W-1:0]     i_tuser,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    // ok[0], read_value[32:1], found_position[39:33], entry_count[46:40],
    // is_empty[47], is_full[48]
    output logic [bole_pkg::OUT_TDATA_W-1:0]  o_tdata
);

    import bole_pkg::*;

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FINAL
    } t_state;

    function automatic logic [VW-1:0] to_store(input logic [ITEM_W-1:0] x);
        logic signed [ITEM_W-1:0] sx;
        logic signed [63:0]       w;
        sx = x;
        w  = 64'(sx);
        return w[VW-1:0];
    endfunction

    function automatic logic [ITEM_W-1:0] to_out(input logic [VW-1:0] x);
        logic signed [VW-1:0] sx;
        logic signed [63:0]   w;
        sx = x;
        w  = 64'(sx);
        return w[ITEM_W-1:0];
    endfunction

    function automatic logic [POSITION_W-1:0] to_field(input logic [CW-1:0] x);
        logic [PW-1:0] w;
        w = PW'(x);
        return w[POSITION_W-1:0];
    endfunction

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [OPCODE_W-1:0]    r_op, n_op;
    logic [CW-1:0]          r_pos, n_pos;
    logic [VW-1:0]          r_val, n_val;
    logic                   r_ok, n_ok;
    logic [CW-1:0]          r_found, n_found;
    logic [ITEM_W-1:0]      r_rdv, n_rdv;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_paddr, n_paddr;
    logic                   r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_otdata, n_otdata;

    logic [OPCODE_W-1:0]    in_op;
    logic [POSITION_W-1:0]  in_pos;
    logic [ITEM_W-1:0]      in_val;
    logic [PW-1:0]          pos_x, cnt_x, at_x;
    logic                   in_acc, out_free, pend_act, match;
    logic [CW-1:0]          new_cnt;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VW-1:0]          ram_wdata, ram_rdata;

    bole_ram #(
        .WIDTH(VW),
        .DEPTH(LIST_CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_op  = i_tuser;
    assign in_pos = i_tdata[6:0];
    assign in_val = i_tdata[38:7];
    assign pos_x  = PW'(in_pos);
    assign cnt_x  = PW'(r_cnt);
    assign at_x   = (pos_x < cnt_x) ? pos_x : (cnt_x - PW'(1));

    assign o_tready = (r_state == S_IDLE);
    assign in_acc   = i_tvalid && o_tready;
    assign out_free = !r_ovalid || i_tready;
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_otdata;

    assign pend_act = r_pend && ((r_state == S_WALK) || (r_state == S_DRAIN));
    assign match    = pend_act && (r_op == OP_SEARCH) && (ram_rdata == r_val);

    assign ram_re    = (r_state == S_WALK);
    assign ram_raddr = r_ptr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = r_val;
        if (pend_act && (r_op == OP_INSERT)) begin
            ram_we    = 1'b1;
            ram_waddr = r_paddr + AW'(1);
            ram_wdata = ram_rdata;
        end else if (pend_act && (r_op == OP_REMOVE)) begin
            ram_we    = 1'b1;
            ram_waddr = r_paddr - AW'(1);
            ram_wdata = ram_rdata;
        end else if ((r_state == S_FINAL) && out_free && r_ok &&
                     ((r_op == OP_INSERT) || (r_op == OP_REPLACE))) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        new_cnt = r_cnt;
        if (r_ok && (r_op == OP_INSERT)) begin
            new_cnt = r_cnt + CW'(1);
        end else if (r_ok && (r_op == OP_REMOVE)) begin
            new_cnt = r_cnt - CW'(1);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_ok     = r_ok;
        n_found  = r_found;
        n_rdv    = r_rdv;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_pend   = r_pend;
        n_paddr  = r_paddr;
        n_ovalid = r_ovalid;
        n_otdata = r_otdata;

        if (r_ovalid && i_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = in_op;
                    n_val   = to_store(in_val);
                    n_ok    = 1'b0;
                    n_found = '0;
                    n_rdv   = '0;
                    n_pend  = 1'b0;
                    n_pos   = CW'(pos_x);
                    n_state = S_FINAL;
                    case (in_op)
                        OP_INSERT: begin
                            if ((cnt_x < PW'(LIST_CAPACITY)) && (pos_x <= cnt_x)) begin
                                n_ok = 1'b1;
                                if (pos_x < cnt_x) begin
                                    n_ptr   = AW'(cnt_x - PW'(1));
                                    n_left  = CW'(cnt_x - pos_x);
                                    n_state = S_WALK;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_x < cnt_x) begin
                                n_ok = 1'b1;
                                if ((pos_x + PW'(1)) < cnt_x) begin
                                    n_ptr   = AW'(pos_x + PW'(1));
                                    n_left  = CW'(cnt_x - pos_x - PW'(1));
                                    n_state = S_WALK;
                                end
                            end
                        end
                        OP_SELECT: begin
                            if (r_cnt != '0) begin
                                n_ok    = 1'b1;
                                n_ptr   = AW'(at_x);
                                n_left  = CW'(1);
                                n_state = S_WALK;
                            end
                        end
                        OP_SEARCH: begin
                            n_found = r_cnt;
                            if (r_cnt != '0) begin
                                n_ptr   = '0;
                                n_left  = r_cnt;
                                n_state = S_WALK;
                            end
                        end
                        OP_REPLACE: begin
                            n_ok = (pos_x < cnt_x);
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_pend  = 1'b1;
                n_paddr = r_ptr;
                n_ptr   = (r_op == OP_INSERT) ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                n_left  = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_DRAIN;
                end
                if (pend_act && (r_op == OP_SELECT)) begin
                    n_rdv = to_out(ram_rdata);
                end
                if (match) begin
                    n_ok    = 1'b1;
                    n_found = CW'(r_paddr);
                    n_pend  = 1'b0;
                    n_state = S_FINAL;
                end
            end
            S_DRAIN: begin
                n_pend  = 1'b0;
                n_state = S_FINAL;
                if (pend_act && (r_op == OP_SELECT)) begin
                    n_rdv = to_out(ram_rdata);
                end
                if (match) begin
                    n_ok    = 1'b1;
                    n_found = CW'(r_paddr);
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_cnt    = new_cnt;
                    n_ovalid = 1'b1;
                    n_otdata = {7'd0,
                                (new_cnt == CW'(LIST_CAPACITY)),
                                (new_cnt == '0),
                                to_field(new_cnt),
                                to_field(r_found),
                                r_rdv,
                                r_ok};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_found  <= n_found;
        r_rdv    <= n_rdv;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_paddr  <= n_paddr;
        r_otdata <= n_otdata;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(LIST_CAPACITY))
        else $error("list count above capacity");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("RAM read and write at the same entry");

    a_result_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_tvalid)) |-> ($past(r_state) == S_FINAL))
        else $error("result item raised outside the final step");

    a_cnt_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt != $past(r_cnt))) |->
        (($past(r_state) == S_FINAL) &&
         ((r_cnt == $past(r_cnt) + CW'(1)) || (r_cnt == $past(r_cnt) - CW'(1)))))
        else $error("count changed outside the final step or by more than one");

endmodule

[tb/bounded_ordered_list_engine_tb.sv]
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;

    import bole_pkg::*;

    localparam int CAP          = DEF_LIST_CAPACITY;
    localparam int PHASE_ITEMS  = 234;
    localparam int TAIL_CYCLES  = 80;

    localparam logic [OPCODE_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic                  ok;
        logic [ITEM_W-1:0]     read_value;
        logic [POSITION_W-1:0] found_position;
        logic [POSITION_W-1:0] entry_count;
        logic                  is_empty;
        logic                  is_full;
    } t_list_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_tvalid;
    logic                   o_tready;
    // position[6:0], item_value[38:7]
    logic [IN_TDATA_W-1:0]  i_tdata;
    // opcode[2:0]
    logic [OPCODE_W-1:0]    i_tuser;
    logic                   o_tvalid;
    logic                   i_tready;
    // ok[0], read_value[32:1], found_position[39:33], entry_count[46:40],
    // is_empty[47], is_full[48]
    logic [OUT_TDATA_W-1:0] o_tdata;

    int tx_idle_pct;
    int rx_idle_pct;

    bounded_ordered_list_engine u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .i_tuser  (i_tuser),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata)
    );

    class list_scoreboard;
        logic [ITEM_W-1:0] entries [CAP];
        int                count;
        t_list_result      result_q [$];
        int                errors;
        int                results;
        int                rejects;
        int                full_seen;
        int                empty_seen;

        function new();
            count = 0;
            errors = 0;
            results = 0;
            rejects = 0;
            full_seen = 0;
            empty_seen = 0;
            foreach (entries[k]) entries[k] = '0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void note_op(input logic [OPCODE_W-1:0] op,
                              input logic [IN_TDATA_W-1:0] word);
            logic [ITEM_W-1:0]   v;
            int                  p;
            int                  i;
            t_list_result        r;
            p  = int'(word[6:0]);
            v  = word[38:7];
            r  = '0;
            case (op)
                OP_INSERT: begin
                    if (count < CAP && p <= count) begin
                        for (i = count; i > p; i--) entries[i] = entries[i-1];
                        entries[p] = v;
                        count++;
                        r.ok = 1'b1;
                        if (count == CAP) full_seen++;
                    end
                end
                OP_REMOVE: begin
                    if (p < count) begin
                        for (i = p; i + 1 < count; i++) entries[i] = entries[i+1];
                        count--;
                        r.ok = 1'b1;
                        if (count == 0) empty_seen++;
                    end
                end
                OP_SELECT: begin
                    if (count > 0) begin
                        r.read_value = entries[(p < count) ? p : count - 1];
                        r.ok = 1'b1;
                    end
                end
                OP_SEARCH: begin
                    r.found_position = POSITION_W'(count);
                    for (i = 0; i < count; i++) begin
                        if (entries[i] == v) begin
                            r.found_position = POSITION_W'(i);
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
                OP_REPLACE: begin
                    if (p < count) begin
                        entries[p] = v;
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!r.ok) rejects++;
            r.entry_count = POSITION_W'(count);
            r.is_empty    = (count == 0);
            r.is_full     = (count == CAP);
            result_q.push_back(r);
        endfunction

        task report_mismatch(input string field, input logic [ITEM_W-1:0] got_v,
                             input logic [ITEM_W-1:0] want_v);
            errors++;
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $time, results, field, got_v, want_v);
        endtask

        task check_result(input logic [OUT_TDATA_W-1:0] word);
            t_list_result got;
            t_list_result want;
            got.ok             = word[0];
            got.read_value     = word[32:1];
            got.found_position = word[39:33];
            got.entry_count    = word[46:40];
            got.is_empty       = word[47];
            got.is_full        = word[48];
            results++;
            if (result_q.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            want = result_q.pop_front();
            if (got.ok !== want.ok)
                report_mismatch("ok", got.ok, want.ok);
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.found_position !== want.found_position)
                report_mismatch("found_position", got.found_position, want.found_position);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", got.is_empty, want.is_empty);
            if (got.is_full !== want.is_full)
                report_mismatch("is_full", got.is_full, want.is_full);
        endtask
    endclass

    list_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_tvalid && o_tready) sb.note_op(i_tuser, i_tdata);
            if (o_tvalid && i_tready) sb.check_result(o_tdata);
        end
    end

    always @(posedge i_clk) begin
        i_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_op(input logic [OPCODE_W-1:0] op, input int pos,
                           input logic [ITEM_W-1:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= {1'b0, val, POSITION_W'(pos)};
        i_tuser  <= op;
        do @(posedge i_clk); while (!o_tready);
    endtask

    task automatic hold_until_drained();
        i_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            4, 5:    return ITEM_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // fill toward full, then drain toward empty, with the rest mixed in
    task automatic run_random(input int n);
        logic [OPCODE_W-1:0] op;
        logic [ITEM_W-1:0]   val;
        int                  pos;
        int                  cnt;
        int                  pick;
        bit                  filling;
        filling = 1'b1;
        for (int k = 0; k < n; k++) begin
            cnt = sb.count;
            if (cnt == CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (cnt == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 3)       op = OPCODE_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            else if (pick < 58) op = filling ? OP_INSERT : OP_REMOVE;
            else if (pick < 68) op = filling ? OP_REMOVE : OP_INSERT;
            else if (pick < 80) op = OP_SELECT;
            else if (pick < 92) op = OP_SEARCH;
            else                op = OP_REPLACE;

            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, 127);
            end else if (op == OP_INSERT) begin
                case ($urandom_range(0, 3))
                    0:       pos = 0;
                    1:       pos = cnt;
                    default: pos = $urandom_range(0, cnt);
                endcase
            end else begin
                pos = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
            end

            if (op == OP_SEARCH && cnt > 0 && $urandom_range(0, 9) < 6)
                val = sb.entries[$urandom_range(0, cnt - 1)];
            else
                val = pick_value();

            if ($urandom_range(0, 199) == 0) hold_until_drained();
            send_op(op, pos, val);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_tvalid    <= 1'b0;
        i_tdata     <= '0;
        i_tuser     <= '0;
        i_tready    <= 1'b0;
        tx_idle_pct = 17;
        rx_idle_pct = 56;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send_op(OP_SELECT,  0,   32'h0);
        send_op(OP_REMOVE,  0,   32'h0);
        send_op(OP_SEARCH,  0,   32'h0);
        send_op(OP_REPLACE, 0,   32'h1);
        send_op(OP_INSERT,  1,   32'h2);
        // build a short list with the value extremes, then select, search, replace, remove and reserved ops
        send_op(OP_INSERT,  0,   32'h8000_0000);
        send_op(OP_INSERT,  1,   32'h7FFF_FFFF);
        send_op(OP_INSERT,  0,   32'hFFFF_FFFF);
        send_op(OP_INSERT,  3,   32'h0);
        send_op(OP_INSERT,  127, 32'h3);
        send_op(OP_SELECT,  127, 32'h0);
        send_op(OP_SELECT,  1,   32'h0);
        send_op(OP_SEARCH,  0,   32'h7FFF_FFFF);
        send_op(OP_SEARCH,  0,   32'h0001_2345);
        send_op(OP_REPLACE, 0,   32'h5555_5555);
        send_op(OP_REPLACE, 64,  32'hAAAA_AAAA);
        send_op(OP_REMOVE,  4,   32'h0);
        send_op(OP_REMOVE,  0,   32'h0);
        send_op(OP_REMOVE,  2,   32'h0);
        send_op(OP_RSVD_LO,  127, 32'hFFFF_FFFF);
        send_op(OP_RSVD_MID, 64,  32'h0);
        send_op(OP_RSVD_HI,  0,   32'h1234_5678);
        hold_until_drained();

        run_random(PHASE_ITEMS);
        hold_until_drained();
        tx_idle_pct = 56;
        rx_idle_pct = 17;
        run_random(PHASE_ITEMS);
        hold_until_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d operation results, %0d of them rejected.",
                 sb.results, sb.rejects);
        $display("The list was filled to capacity %0d times and emptied %0d times.",
                 sb.full_seen, sb.empty_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
